// ----- src/rpd_pkg.sv -----
// Shared types, constants and helpers for the polyline resampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rpd_pkg;

  localparam int CRD_W = 32;   // coordinate field width
  localparam int REG_W = 31;   // configuration register width
  localparam int CNT_W = 7;    // point count per segment (up to 64)
  localparam int IDX_W = 2;    // configuration index width

  localparam logic [IDX_W-1:0] REG_STEP = 2'd0;
  localparam logic [IDX_W-1:0] REG_JUMP = 2'd1;
  localparam logic [IDX_W-1:0] REG_NODE = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLR,
    CMD_ZERO,
    CMD_SEG
  } cmd_kind_t;

  // One job (clear, zero-length or segment) handed from the front to the back.
  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [CRD_W-1:0]  px;
    logic signed [CRD_W-1:0]  py;
    logic [REG_W-1:0]         adx;
    logic [REG_W-1:0]         ady;
    logic                     negx;
    logic                     negy;
    logic [REG_W-1:0]         len;
    logic [REG_W-1:0]         stp;
    logic [CNT_W-1:0]         n;
  } cmd_t;

  // Clamp to the symmetric-ish signed range [-cmax-1, cmax].
  function automatic logic signed [CRD_W-1:0] sat_crd(
    input logic signed [47:0] v,
    input logic signed [47:0] cmax
  );
    logic signed [47:0] cmin;
    logic signed [47:0] r;
    cmin = -cmax - 48'sd1;
    if (v > cmax) r = cmax;
    else if (v < cmin) r = cmin;
    else r = v;
    return r[CRD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/rpd_if.sv -----
// Channel interfaces: input points, result words and configuration writes.
// Depends on rpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rpd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpd_pkg::CRD_W-1:0]  point_x;
  logic signed [rpd_pkg::CRD_W-1:0]  point_y;
  logic                              start_of_path;
  modport source (output valid, point_x, point_y, start_of_path, input ready);
  modport sink (input valid, point_x, point_y, start_of_path, output ready);
endinterface

interface rpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpd_pkg::CRD_W-1:0]  interp_x;
  logic signed [rpd_pkg::CRD_W-1:0]  interp_y;
  logic                              node_valid;
  logic signed [rpd_pkg::CRD_W-1:0]  node_x;
  logic signed [rpd_pkg::CRD_W-1:0]  node_y;
  logic                              last_of_run;
  modport source (output valid, interp_x, interp_y, node_valid, node_x, node_y,
                  last_of_run, input ready);
  modport sink (input valid, interp_x, interp_y, node_valid, node_x, node_y,
                last_of_run, output ready);
endinterface

interface rpd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rpd_pkg::IDX_W-1:0]   addr;
  logic [31:0]                 data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- src/polyline_resample_and_decimate.sv -----
// Polyline resampler: front (rpd_front) -> 2-word job queue -> back (rpd_back).
// The front finds each segment's length with a root and its point count with a
// division; the back spends two offset divisions and, once a word has been
// emitted, a distance root on each word. Neither end takes new work until
// the current point or job is done. Synchronous active-low reset clears the
// control state and loads the register reset values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module polyline_resample_and_decimate #(
  parameter int MAX_POINTS_PER_SEGMENT = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rpd_in_if.sink    in_ch,
  rpd_out_if.source out_ch,
  rpd_cfg_if.sink   cfg_ch
);

  localparam int RW = rpd_pkg::REG_W;

  // configuration registers, written by the user only while the block is idle; the block itself does not enforce this
  logic [RW-1:0] step_r, jump_r, node_r;

  // job queue between front and back
  rpd_pkg::cmd_t q_mem_r [2];
  logic          q_wr_r, q_rd_r;
  logic [1:0]    q_cnt_r;
  logic          q_push, q_pop;

  rpd_pkg::cmd_t f_cmd;
  logic          f_valid;
  logic          b_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= RW'(6554);
      jump_r <= RW'(327680);
      node_r <= RW'(19661);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        rpd_pkg::REG_STEP: step_r <= cfg_ch.data[RW-1:0];
        rpd_pkg::REG_JUMP: jump_r <= cfg_ch.data[RW-1:0];
        rpd_pkg::REG_NODE: node_r <= cfg_ch.data[RW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  rpd_front #(
    .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT),
    .COORD_WIDTH            (COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .step_length (step_r),
    .jump_limit  (jump_r),
    .cmd         (f_cmd),
    .cmd_valid   (f_valid),
    .cmd_ready   (q_cnt_r != 2'd2)
  );

  assign q_push = f_valid && (q_cnt_r != 2'd2);
  assign q_pop  = (q_cnt_r != 2'd0) && b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (q_push) begin
        q_mem_r[q_wr_r] <= f_cmd;
        q_wr_r          <= ~q_wr_r;
      end
      if (q_pop) q_rd_r <= ~q_rd_r;
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  rpd_back #(
    .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT),
    .COORD_WIDTH            (COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (q_mem_r[q_rd_r]),
    .cmd_valid    (q_cnt_r != 2'd0),
    .cmd_ready    (b_ready),
    .node_spacing (node_r),
    .out_ch       (out_ch)
  );

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("job queue count out of range");
  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |=> q_cnt_r == $past(q_cnt_r) + 2'd1)
    else $error("job queue count did not track a push");
  a_q_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd0) |-> (q_wr_r == q_rd_r))
    else $error("job queue pointers disagree while empty");
`endif

endmodule
`default_nettype wire

// ----- src/rpd_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rpd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [63:0] bit_w;
  logic [63:0] trial;

  assign bit_w = 64'd1 << {cnt_r, 1'b0};
  assign trial = r_r + bit_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= val;
        r_r   <= '0;
        cnt_r <= 5'd31;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_w;
        end else begin
          r_r <= r_r >> 1;
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule
`default_nettype wire

// ----- src/rpd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rpd_div #(
  parameter int NW = 31,
  parameter int DW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   trial;

  assign trial = {rem_r, q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CW'(NW - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DW'(trial - {1'b0, den_r});
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DW-1:0];
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

// ----- src/rpd_front.sv -----
// Front end: takes points, checks for teleports, finds segment length and
// point count, and hands one job per segment (or a clear job at a path start)
// to the back. Uses rpd_pkg, rpd_if, rpd_isqrt, rpd_div.
`timescale 1ns / 1ps
`default_nettype none
module rpd_front #(
  parameter int MAX_POINTS_PER_SEGMENT = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rpd_in_if.sink                           in_ch,
  input  wire logic [rpd_pkg::REG_W-1:0]   step_length,
  input  wire logic [rpd_pkg::REG_W-1:0]   jump_limit,
  output rpd_pkg::cmd_t                    cmd,
  output logic                             cmd_valid,
  input  wire logic                        cmd_ready
);

  localparam int CW_EFF = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [47:0] CMAX = (48'sd1 <<< (CW_EFF - 1)) - 48'sd1;
  localparam int RW = rpd_pkg::REG_W;
  localparam int NBW = rpd_pkg::CNT_W;

  typedef enum logic [2:0] {
    F_IDLE, F_SQX, F_SQY, F_CHK, F_ROOT, F_DIV, F_PUSH
  } fstate_t;

  fstate_t                         state_r;
  logic signed [rpd_pkg::CRD_W-1:0] prev_x_r, prev_y_r;
  logic                            have_prev_r;
  rpd_pkg::cmd_t                   cmd_r;
  logic [RW-1:0]                   ax_r, ay_r;
  logic [2*RW-1:0]                 sq_r;
  logic [2*RW:0]                   sum_r;

  logic signed [rpd_pkg::CRD_W-1:0] xs, ys;
  logic signed [32:0]              dxw, dyw;
  logic [32:0]                     axw, ayw;
  logic                            tele;
  logic [RW-1:0]                   mul_a;
  logic [2*RW-1:0]                 mul_p;
  logic                            sq_start, sq_done;
  logic [31:0]                     sq_root;
  logic                            dv_start, dv_done;
  logic [RW-1:0]                   dv_quo;
  logic [NBW-1:0]                  n_w;

  always_comb begin
    xs   = rpd_pkg::sat_crd(48'(in_ch.point_x), CMAX);
    ys   = rpd_pkg::sat_crd(48'(in_ch.point_y), CMAX);
    dxw  = 33'(xs) - 33'(prev_x_r);
    dyw  = 33'(ys) - 33'(prev_y_r);
    axw  = dxw[32] ? 33'(-dxw) : 33'(dxw);
    ayw  = dyw[32] ? 33'(-dyw) : 33'(dyw);
    tele = (axw > {2'b00, jump_limit}) || (ayw > {2'b00, jump_limit});
  end

  // one squarer shared by the x, y and limit squares
  always_comb begin
    case (state_r)
      F_SQX:   mul_a = ax_r;
      F_SQY:   mul_a = ay_r;
      default: mul_a = jump_limit;
    endcase
    mul_p = mul_a * mul_a;
  end

  assign sq_start = (state_r == F_CHK) && (sum_r <= {1'b0, mul_p}) && (sum_r != '0);
  assign dv_start = (state_r == F_ROOT) && sq_done;

  always_comb begin
    if (dv_quo == '0) n_w = NBW'(1);
    else if (dv_quo > RW'(MAX_POINTS_PER_SEGMENT)) n_w = NBW'(MAX_POINTS_PER_SEGMENT);
    else n_w = dv_quo[NBW-1:0];
  end

  rpd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   ({1'b0, sum_r}),
    .done  (sq_done),
    .root  (sq_root)
  );

  rpd_div #(.NW(RW), .DW(RW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (sq_root[RW-1:0]),
    .den   (cmd_r.stp),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            prev_x_r    <= xs;
            prev_y_r    <= ys;
            have_prev_r <= 1'b1;
            cmd_r.px    <= prev_x_r;
            cmd_r.py    <= prev_y_r;
            cmd_r.negx  <= dxw[32];
            cmd_r.negy  <= dyw[32];
            cmd_r.stp   <= (step_length == '0) ? RW'(1) : step_length;
            ax_r        <= axw[RW-1:0];
            ay_r        <= ayw[RW-1:0];
            cmd_r.adx   <= axw[RW-1:0];
            cmd_r.ady   <= ayw[RW-1:0];
            if (in_ch.start_of_path || !have_prev_r) begin
              cmd_r.kind <= rpd_pkg::CMD_CLR;
              state_r    <= F_PUSH;
            end else if (!tele) begin
              state_r <= F_SQX;
            end
          end
        end
        F_SQX: begin
          sq_r    <= mul_p;
          state_r <= F_SQY;
        end
        F_SQY: begin
          sum_r   <= {1'b0, sq_r} + {1'b0, mul_p};
          state_r <= F_CHK;
        end
        F_CHK: begin
          if (sum_r > {1'b0, mul_p}) begin
            state_r <= F_IDLE;             // teleport by distance
          end else if (sum_r == '0) begin
            cmd_r.kind <= rpd_pkg::CMD_ZERO;
            state_r    <= F_PUSH;
          end else begin
            state_r <= F_ROOT;
          end
        end
        F_ROOT: begin
          if (sq_done) begin
            cmd_r.len <= sq_root[RW-1:0];
            state_r   <= F_DIV;
          end
        end
        F_DIV: begin
          if (dv_done) begin
            cmd_r.n    <= n_w;
            cmd_r.kind <= rpd_pkg::CMD_SEG;
            state_r    <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (cmd_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == F_IDLE);
  assign cmd_valid   = (state_r == F_PUSH);
  assign cmd         = cmd_r;

endmodule
`default_nettype wire

// ----- src/rpd_back.sv -----
// Back end: steps each job along its segment, accumulates emitted length,
// flags simplified nodes and drives the result register.
// Uses rpd_pkg, rpd_if, rpd_isqrt, rpd_div.
`timescale 1ns / 1ps
`default_nettype none
module rpd_back #(
  parameter int MAX_POINTS_PER_SEGMENT = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rpd_pkg::cmd_t               cmd,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire logic [rpd_pkg::REG_W-1:0]   node_spacing,
  rpd_out_if.source                        out_ch
);

  localparam int CW_EFF = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [47:0] CMAX = (48'sd1 <<< (CW_EFF - 1)) - 48'sd1;
  localparam int RW = rpd_pkg::REG_W;
  localparam int CRW = rpd_pkg::CRD_W;
  localparam int TW = RW + $clog2(MAX_POINTS_PER_SEGMENT + 1);
  localparam int TH = (TW + 1) / 2;
  localparam int NW = RW + TW + 1;

  typedef enum logic [3:0] {
    B_IDLE, B_MH, B_ML, B_ADD, B_DIV, B_DSQX, B_DSQY, B_ROOT, B_OUT
  } bstate_t;

  bstate_t                    state_r;
  rpd_pkg::cmd_t              cmd_r;
  logic [rpd_pkg::CNT_W-1:0]  k_r;
  logic [TW-1:0]              t_r;
  logic                       axis_r;
  logic                       last_r;
  logic [2*RW-1:0]            ph_r, pl_r, sq_r;
  logic [NW-1:0]              num_r;
  logic                       div_go_r, root_go_r;
  logic [63:0]                dsum_r;
  logic [31:0]                dist_r;
  logic signed [CRW-1:0]      cx_r, cy_r, ex_r, ey_r;
  logic                       have_em_r;
  logic [31:0]                ls_r;
  logic                       ov_r, onv_r, olast_r;
  logic signed [CRW-1:0]      ox_r, oy_r, onx_r, ony_r;

  logic [RW-1:0]              mul_a, mul_b, mag;
  logic [2*RW-1:0]            mul_p;
  logic                       dv_done, rt_done;
  logic [NW-1:0]              dv_quo;
  logic [31:0]                rt_root;
  logic signed [47:0]         base48, off48, v48;
  logic signed [CRW-1:0]      coord;
  logic signed [32:0]         ddx, ddy;
  logic [32:0]                adx, ady;
  logic [RW-1:0]              mx, my;
  logic [32:0]                s33;
  logic [31:0]                s_sat;
  logic                       node;
  logic                       load;

  always_comb begin
    mag    = axis_r ? cmd_r.ady : cmd_r.adx;
    base48 = axis_r ? 48'(cmd_r.py) : 48'(cmd_r.px);
    off48  = signed'(48'(dv_quo[TW-1:0]));
    v48    = (axis_r ? cmd_r.negy : cmd_r.negx) ? base48 - off48 : base48 + off48;
    coord  = rpd_pkg::sat_crd(v48, CMAX);
    ddx    = 33'(cx_r) - 33'(ex_r);
    ddy    = 33'(cy_r) - 33'(ey_r);
    adx    = ddx[32] ? 33'(-ddx) : 33'(ddx);
    ady    = ddy[32] ? 33'(-ddy) : 33'(ddy);
    mx     = (adx > 33'h07FFFFFFF) ? {RW{1'b1}} : adx[RW-1:0];
    my     = (ady > 33'h07FFFFFFF) ? {RW{1'b1}} : ady[RW-1:0];
    s33    = 33'(ls_r) + 33'(dist_r);
    s_sat  = s33[32] ? 32'hFFFF_FFFF : s33[31:0];
    node   = have_em_r && (s_sat > {1'b0, node_spacing});
    load   = (state_r == B_OUT) && (!ov_r || out_ch.ready);
  end

  // shared multiplier: offset partial products and distance squares
  always_comb begin
    case (state_r)
      B_MH: begin
        mul_a = mag;
        mul_b = RW'(t_r[TW-1:TH]);
      end
      B_ML: begin
        mul_a = mag;
        mul_b = RW'(t_r[TH-1:0]);
      end
      B_DSQX: begin
        mul_a = mx;
        mul_b = mx;
      end
      default: begin
        mul_a = my;
        mul_b = my;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  rpd_div #(.NW(NW), .DW(RW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (cmd_r.len),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  rpd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_go_r),
    .val   (dsum_r),
    .done  (rt_done),
    .root  (rt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      div_go_r  <= 1'b0;
      root_go_r <= 1'b0;
      have_em_r <= 1'b0;
      ex_r      <= '0;
      ey_r      <= '0;
      ls_r      <= '0;
      ov_r      <= 1'b0;
    end else begin
      div_go_r  <= 1'b0;
      root_go_r <= 1'b0;
      if (ov_r && out_ch.ready && !load) ov_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_r  <= cmd;
            k_r    <= rpd_pkg::CNT_W'(1);
            t_r    <= TW'(cmd.stp);
            axis_r <= 1'b0;
            cx_r   <= cmd.px;
            cy_r   <= cmd.py;
            last_r <= 1'b1;
            case (cmd.kind)
              rpd_pkg::CMD_CLR: begin
                have_em_r <= 1'b0;
                ex_r      <= '0;
                ey_r      <= '0;
                ls_r      <= '0;
              end
              rpd_pkg::CMD_ZERO: state_r <= have_em_r ? B_DSQX : B_OUT;
              rpd_pkg::CMD_SEG: begin
                last_r  <= (cmd.n == rpd_pkg::CNT_W'(1));
                state_r <= B_MH;
              end
              default: state_r <= B_IDLE;
            endcase
          end
        end
        B_MH: begin
          ph_r    <= mul_p;
          state_r <= B_ML;
        end
        B_ML: begin
          pl_r    <= mul_p;
          state_r <= B_ADD;
        end
        B_ADD: begin
          num_r    <= (NW'(ph_r) << TH) + NW'(pl_r) + NW'(cmd_r.len[RW-1:1]);
          div_go_r <= 1'b1;
          state_r  <= B_DIV;
        end
        B_DIV: begin
          if (dv_done) begin
            if (!axis_r) begin
              cx_r    <= coord;
              axis_r  <= 1'b1;
              state_r <= B_MH;
            end else begin
              cy_r    <= coord;
              state_r <= have_em_r ? B_DSQX : B_OUT;
            end
          end
        end
        B_DSQX: begin
          sq_r    <= mul_p;
          state_r <= B_DSQY;
        end
        B_DSQY: begin
          dsum_r    <= 64'(sq_r) + 64'(mul_p);
          root_go_r <= 1'b1;
          state_r   <= B_ROOT;
        end
        B_ROOT: begin
          if (rt_done) begin
            dist_r  <= rt_root;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (load) begin
            ov_r      <= 1'b1;
            ox_r      <= cx_r;
            oy_r      <= cy_r;
            onv_r     <= node;
            onx_r     <= node ? ex_r : '0;
            ony_r     <= node ? ey_r : '0;
            olast_r   <= last_r;
            if (have_em_r) ls_r <= node ? '0 : s_sat;
            ex_r      <= cx_r;
            ey_r      <= cy_r;
            have_em_r <= 1'b1;
            k_r       <= k_r + rpd_pkg::CNT_W'(1);
            t_r       <= t_r + TW'(cmd_r.stp);
            axis_r    <= 1'b0;
            last_r    <= (k_r + rpd_pkg::CNT_W'(1)) == cmd_r.n;
            state_r   <= last_r ? B_IDLE : B_MH;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign cmd_ready          = (state_r == B_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.interp_x    = ox_r;
  assign out_ch.interp_y    = oy_r;
  assign out_ch.node_valid  = onv_r;
  assign out_ch.node_x      = onx_r;
  assign out_ch.node_y      = ony_r;
  assign out_ch.last_of_run = olast_r;

endmodule
`default_nettype wire
